### src/gradient_noise_3d_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gradient noise sampler
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_3D_SAMPLER_UNIT_MACROS_SVH
`define GRADIENT_NOISE_3D_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define GN3S_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gn3s assertion failed");

// next-cycle implication
`define GN3S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gn3s assertion failed");

`endif

### src/gn3s_pkg.sv
// ----------------------------------------------------------------------------
// gn3s_pkg
// Shared types and constants of the gradient noise sampler.
// ----------------------------------------------------------------------------
package gn3s_pkg;

  localparam int TBL_DEPTH = 256;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  we;
    byte_t addr;
    byte_t data;
  } perm_wr_t;

endpackage

### src/gradient_noise_3d_sampler_unit.sv
// A sample beat passes through the pipeline stages and then the output register before it shows on the output.
// Throughput: one beat per cycle; the whole pipeline stalls only while a
// finished result waits at the output register.
// The table lookups are three levels of replicated 2-read-port table copies.
// Reset clears offsets and pipeline valids; the table is undefined until loaded.
// ----------------------------------------------------------------------------
// gradient_noise_3d_sampler_unit
// Improved Perlin noise in 3D: table load beats and sample beats in one stream.
// ----------------------------------------------------------------------------
module gradient_noise_3d_sampler_unit #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic signed [39:0] x_coord_i,
  input  logic signed [39:0] y_coord_i,
  input  logic signed [39:0] z_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] noise_value_o
);

  localparam logic [1:0] REG_OFF_X = 2'd0;
  localparam logic [1:0] REG_OFF_Y = 2'd1;
  localparam logic [1:0] REG_OFF_Z = 2'd2;
  localparam int SH = 16 - OUT_FRAC_BITS;
  localparam logic signed [21:0] RND_BIAS = 22'sd1 <<< (SH - 1);
  localparam logic signed [21:0] HI_LIM = (OUT_FRAC_BITS >= 15) ? 22'sd32767
                                          : (22'sd1 <<< OUT_FRAC_BITS);
  localparam logic signed [21:0] LO_LIM = -(22'sd1 <<< OUT_FRAC_BITS);

  typedef gn3s_pkg::byte_t byte_t;

  function automatic logic signed [20:0] grad_dot(logic [3:0] h, logic signed [17:0] x,
                                                  logic signed [17:0] y,
                                                  logic signed [17:0] z);
    logic signed [20:0] a, b, c;
    a = 21'(x);
    b = 21'(y);
    c = 21'(z);
    case (h)
      4'd0:    grad_dot = a + b;
      4'd1:    grad_dot = b - a;
      4'd2:    grad_dot = a - b;
      4'd3:    grad_dot = -a - b;
      4'd4:    grad_dot = a + c;
      4'd5:    grad_dot = c - a;
      4'd6:    grad_dot = a - c;
      4'd7:    grad_dot = -a - c;
      4'd8:    grad_dot = b + c;
      4'd9:    grad_dot = c - b;
      4'd10:   grad_dot = b - c;
      4'd11:   grad_dot = -b - c;
      4'd12:   grad_dot = a + b;
      4'd13:   grad_dot = c - b;
      4'd14:   grad_dot = b - a;
      default: grad_dot = -b - c;
    endcase
  endfunction

  function automatic logic signed [20:0] lerp(logic [16:0] s, logic signed [20:0] a,
                                              logic signed [20:0] b);
    logic signed [21:0] d;
    logic signed [39:0] m;
    d = $signed({b[20], b}) - $signed({a[20], a});
    m = $signed({1'b0, s}) * d;
    m = m + 40'sd32768;
    lerp = a + 21'(m >>> 16);
  endfunction

  // configuration
  logic [23:0] off_q [3];
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_OFF_X: off_q[0] <= pwdata[23:0];
        REG_OFF_Y: off_q[1] <= pwdata[23:0];
        REG_OFF_Z: off_q[2] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OFF_X: prdata = {8'd0, off_q[0]};
      REG_OFF_Y: prdata = {8'd0, off_q[1]};
      REG_OFF_Z: prdata = {8'd0, off_q[2]};
      default:   prdata = '0;
    endcase
  end

  // pipeline control
  logic       en;
  logic [8:1] v_q, k_q;
  logic       out_vld_q;

  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v_q       <= {v_q[7:1], in_valid_i};
      k_q       <= {k_q[7:1], kind_i};
      out_vld_q <= v_q[8] & k_q[8];
    end
  end

  // stage 1: cell and fraction
  logic signed [39:0] crd [3];
  byte_t       cell_d [3];
  logic [15:0] frac_d [3];

  assign crd[0] = x_coord_i;
  assign crd[1] = y_coord_i;
  assign crd[2] = z_coord_i;

  for (genvar a = 0; a < 3; a++) begin : g_split
    logic signed [40:0] sum;
    assign sum       = $signed({crd[a][39], crd[a]}) + $signed({17'd0, off_q[a]});
    assign cell_d[a] = sum[COORD_FRAC_BITS+7:COORD_FRAC_BITS];
    if (COORD_FRAC_BITS >= 16) begin : g_trunc
      assign frac_d[a] = sum[COORD_FRAC_BITS-1 -: 16];
    end else begin : g_shift
      assign frac_d[a] = {sum[COORD_FRAC_BITS-1:0], {(16 - COORD_FRAC_BITS){1'b0}}};
    end
  end

  byte_t       cell1_q [3];
  logic [15:0] f1_q [3], f2_q [3], f3_q [3], f4_q [3];
  byte_t       ti1_q, tv1_q, ti2_q, tv2_q, ti3_q, tv3_q;
  byte_t       cy2_q, cz2_q, cz3_q;
  logic [31:0] sq2_q [3];
  logic [15:0] t3_q [3];
  logic [19:0] pp3_q [3];
  logic [16:0] fade4_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        cell1_q[a] <= cell_d[a];
        f1_q[a]    <= frac_d[a];
        f2_q[a]    <= f1_q[a];
        f3_q[a]    <= f2_q[a];
        f4_q[a]    <= f3_q[a];
        sq2_q[a]   <= f1_q[a] * f1_q[a];
      end
      ti1_q <= table_index_i;
      tv1_q <= table_value_i;
      ti2_q <= ti1_q;
      tv2_q <= tv1_q;
      ti3_q <= ti2_q;
      tv3_q <= tv2_q;
      cy2_q <= cell1_q[1];
      cz2_q <= cell1_q[2];
      cz3_q <= cz2_q;
    end
  end

  // fade: t^3 and the quadratic factor, then their product
  for (genvar a = 0; a < 3; a++) begin : g_fade
    logic [47:0] cube;
    logic [36:0] inner;
    logic [36:0] prod;
    assign cube  = sq2_q[a] * f2_q[a];
    assign inner = 37'(sq2_q[a]) * 37'd6 + (37'd10 << 32)
                 - ((37'(f2_q[a]) * 37'd15) << 16);
    assign prod  = 37'(t3_q[a]) * 37'(pp3_q[a]) + 37'd32768;
    always_ff @(posedge clk_i) begin
      if (en) begin
        t3_q[a]    <= cube[47:32];
        pp3_q[a]   <= inner[35:16];
        fade4_q[a] <= prod[32:16];
      end
    end
  end

  // table lookups, one level per stage; loads write each level in step
  gn3s_pkg::perm_wr_t wr1, wr2, wr3;
  byte_t h0, h1;
  byte_t ab [4];
  byte_t crn [4][2];

  assign wr1 = '{we: v_q[1] & ~k_q[1] & en, addr: ti1_q, data: tv1_q};
  assign wr2 = '{we: v_q[2] & ~k_q[2] & en, addr: ti2_q, data: tv2_q};
  assign wr3 = '{we: v_q[3] & ~k_q[3] & en, addr: ti3_q, data: tv3_q};

  gn3s_perm_ram u_l1 (
    .clk_i, .en_i(en), .wr_i(wr1),
    .raddr0_i(cell1_q[0]), .raddr1_i(cell1_q[0] + 8'd1),
    .rdata0_o(h0), .rdata1_o(h1)
  );

  // ab: 0 = a0, 1 = b0, 2 = a1, 3 = b1
  gn3s_perm_ram u_l2a (
    .clk_i, .en_i(en), .wr_i(wr2),
    .raddr0_i(h0 + cy2_q), .raddr1_i(h0 + cy2_q + 8'd1),
    .rdata0_o(ab[0]), .rdata1_o(ab[2])
  );

  gn3s_perm_ram u_l2b (
    .clk_i, .en_i(en), .wr_i(wr2),
    .raddr0_i(h1 + cy2_q), .raddr1_i(h1 + cy2_q + 8'd1),
    .rdata0_o(ab[1]), .rdata1_o(ab[3])
  );

  for (genvar c = 0; c < 4; c++) begin : g_l3
    gn3s_perm_ram u_l3 (
      .clk_i, .en_i(en), .wr_i(wr3),
      .raddr0_i(ab[c] + cz3_q), .raddr1_i(ab[c] + cz3_q + 8'd1),
      .rdata0_o(crn[c][0]), .rdata1_o(crn[c][1])
    );
  end

  // stage 5: corner dots, index c = x + 2y + 4z
  logic signed [17:0] d0 [3], d1 [3];
  logic signed [20:0] n5_q [8];
  logic [16:0] sx5_q, sy5_q, sz5_q, sy6_q, sz6_q, sz7_q;
  logic signed [20:0] lx6_q [4], ly7_q [2], val8_q;

  for (genvar a = 0; a < 3; a++) begin : g_delta
    assign d0[a] = $signed({2'b00, f4_q[a]});
    assign d1[a] = $signed({2'b00, f4_q[a]}) - 18'sd65536;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        n5_q[c] <= grad_dot(crn[(c & 1) + ((c >> 1) & 1) * 2][(c >> 2) & 1][3:0],
                            (c & 1) != 0 ? d1[0] : d0[0],
                            (c & 2) != 0 ? d1[1] : d0[1],
                            (c & 4) != 0 ? d1[2] : d0[2]);
      end
      sx5_q <= fade4_q[0];
      sy5_q <= fade4_q[1];
      sz5_q <= fade4_q[2];
      for (int i = 0; i < 4; i++) begin
        lx6_q[i] <= lerp(sx5_q, n5_q[2 * i], n5_q[2 * i + 1]);
      end
      sy6_q <= sy5_q;
      sz6_q <= sz5_q;
      ly7_q[0] <= lerp(sy6_q, lx6_q[0], lx6_q[1]);
      ly7_q[1] <= lerp(sy6_q, lx6_q[2], lx6_q[3]);
      sz7_q <= sz6_q;
      val8_q <= lerp(sz7_q, ly7_q[0], ly7_q[1]);
    end
  end

  // output rounding and saturation
  logic signed [21:0] rnd, sat;
  logic signed [15:0] noise_q;

  always_comb begin
    rnd = ($signed({val8_q[20], val8_q}) + RND_BIAS) >>> SH;
    if (rnd > HI_LIM) begin
      sat = HI_LIM;
    end else if (rnd < LO_LIM) begin
      sat = LO_LIM;
    end else begin
      sat = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= 16'(sat);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign noise_value_o = noise_q;

endmodule

### src/gn3s_perm_ram.sv
// ----------------------------------------------------------------------------
// gn3s_perm_ram
// One copy of the permutation table: one write port, two registered reads.
// ----------------------------------------------------------------------------
module gn3s_perm_ram (
  input  logic              clk_i,
  input  logic              en_i,
  input  gn3s_pkg::perm_wr_t wr_i,
  input  gn3s_pkg::byte_t   raddr0_i,
  input  gn3s_pkg::byte_t   raddr1_i,
  output gn3s_pkg::byte_t   rdata0_o,
  output gn3s_pkg::byte_t   rdata1_o
);

  gn3s_pkg::byte_t mem [gn3s_pkg::TBL_DEPTH];
  gn3s_pkg::byte_t rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (en_i) begin
      rd0_q <= mem[raddr0_i];
      rd1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

### src/gn3s_checker.sv
// ----------------------------------------------------------------------------
// gn3s_checker
// Port-level checks of the gradient noise sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "gradient_noise_3d_sampler_unit_macros.svh"

module gn3s_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pready,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [15:0] noise_value_o
);

  `GN3S_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(noise_value_o))
  `GN3S_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `GN3S_ASSERT_NOW(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o)
  `GN3S_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind gradient_noise_3d_sampler_unit gn3s_checker u_gn3s_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .pready(pready),
  .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .noise_value_o(noise_value_o)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: gradient noise sampler testbench
// Drives table-load and sample beats with bursty valid, random output stalls,
// and APB offset writes between phases. Sample beats are checked in order
// against an in-bench fixed-point noise model, or against a literal in directed rows.
// ----------------------------------------------------------------------------
module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic [7:0]         table_index_i = '0, table_value_i = '0;
  logic signed [39:0] x_coord_i = '0, y_coord_i = '0, z_coord_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] noise_value_o;

  localparam int NOISE_LATENCY = 8;
  localparam bit KIND_LOAD = 1'b0;
  localparam bit KIND_SAMPLE = 1'b1;
  localparam longint CYCLE_LIMIT = 400000;

  gradient_noise_3d_sampler_unit u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  logic [7:0]  perm_copy [256];
  logic [23:0] offs [3];
  logic signed [15:0] noise_q [$];
  int errors = 0, n_samples = 0, n_loads = 0;
  longint cycles = 0;
  bit stall_free = 0;

  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [63:0] fade_q16(logic signed [63:0] t);
    logic [63:0] t3, p;
    t3 = (t * t * t) >> 32;
    p = (6 * t * t - 15 * t * 65536 + (64'sd10 <<< 32)) >>> 16;
    return (t3 * p + 32768) >> 16;
  endfunction

  function automatic logic signed [63:0] lerp_q16(logic signed [63:0] s, a, b);
    return a + rnd_shr(s * (b - a), 16);
  endfunction

  function automatic logic signed [63:0] grad_dot(logic [7:0] h,
      logic signed [63:0] dx, dy, dz);
    case (h[3:0])
      0, 12: return dx + dy;
      1, 14: return -dx + dy;
      2: return dx - dy;
      3: return -dx - dy;
      4: return dx + dz;
      5: return -dx + dz;
      6: return dx - dz;
      7: return -dx - dz;
      8: return dy + dz;
      9, 13: return -dy + dz;
      10: return dy - dz;
      default: return -dy - dz;
    endcase
  endfunction

  function automatic logic signed [15:0] noise_at(logic signed [39:0] xc, yc, zc);
    logic signed [63:0] sum [3];
    logic signed [63:0] f [3], s [3], n [8], lo, hi, v;
    logic [7:0] c [3], h0, h1, a0, a1, b0, b1;
    sum[0] = 64'(xc) + offs[0];
    sum[1] = 64'(yc) + offs[1];
    sum[2] = 64'(zc) + offs[2];
    for (int i = 0; i < 3; i++) begin
      c[i] = sum[i][23:16];
      f[i] = {48'd0, sum[i][15:0]};
      s[i] = fade_q16(f[i]);
    end
    h0 = perm_copy[c[0]];
    h1 = perm_copy[8'(c[0] + 1)];
    a0 = perm_copy[8'(h0 + c[1])];
    a1 = perm_copy[8'(h0 + c[1] + 1)];
    b0 = perm_copy[8'(h1 + c[1])];
    b1 = perm_copy[8'(h1 + c[1] + 1)];
    n[0] = grad_dot(perm_copy[8'(a0 + c[2])], f[0], f[1], f[2]);
    n[1] = grad_dot(perm_copy[8'(b0 + c[2])], f[0] - 65536, f[1], f[2]);
    n[2] = grad_dot(perm_copy[8'(a1 + c[2])], f[0], f[1] - 65536, f[2]);
    n[3] = grad_dot(perm_copy[8'(b1 + c[2])], f[0] - 65536, f[1] - 65536, f[2]);
    n[4] = grad_dot(perm_copy[8'(a0 + c[2] + 1)], f[0], f[1], f[2] - 65536);
    n[5] = grad_dot(perm_copy[8'(b0 + c[2] + 1)], f[0] - 65536, f[1], f[2] - 65536);
    n[6] = grad_dot(perm_copy[8'(a1 + c[2] + 1)], f[0], f[1] - 65536, f[2] - 65536);
    n[7] = grad_dot(perm_copy[8'(b1 + c[2] + 1)], f[0] - 65536, f[1] - 65536,
                    f[2] - 65536);
    lo = lerp_q16(s[1], lerp_q16(s[0], n[0], n[1]), lerp_q16(s[0], n[2], n[3]));
    hi = lerp_q16(s[1], lerp_q16(s[0], n[4], n[5]), lerp_q16(s[0], n[6], n[7]));
    v = rnd_shr(lerp_q16(s[2], lo, hi), 1);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("[gradient_noise_3d_sampler_unit] ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (noise_q.size() == 0) begin
        $display("%0t unexpected beat: actual %0d", $time, noise_value_o);
        errors++;
      end else begin
        if (noise_value_o !== noise_q[0]) begin
          $display("%0t noise mismatch: expected %0d actual %0d", $time,
                   noise_q[0], noise_value_o);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_free) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0) || (cycles % 97 < 20);
  end

  task automatic apb_write(int idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(4 * idx); pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    offs[idx] = val[23:0];
  endtask

  int gap_left = 0;

  // Valid stays up after a beat so the next one can follow at once; callers
  // that idle drop it first.
  // Directed rows use expected when chk_lit is set; otherwise the predictor.
  task automatic send_beat(bit kd, logic [7:0] ix, vl, logic signed [39:0] xc, yc, zc,
                           bit chk_lit = 0, logic signed [15:0] lit = 0);
    if (gap_left > 0) begin
      in_valid_i <= 0;
      repeat (gap_left) @(negedge clk_i);
      gap_left = 0;
    end else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 6);
    in_valid_i <= 1; kind_i <= kd; table_index_i <= ix; table_value_i <= vl;
    x_coord_i <= xc; y_coord_i <= yc; z_coord_i <= zc;
    do @(posedge clk_i); while (!in_ready_o);
    if (kd == KIND_LOAD) begin
      perm_copy[ix] = vl;
      n_loads++;
    end else begin
      noise_q.push_back(chk_lit ? lit : noise_at(xc, yc, zc));
      n_samples++;
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (noise_q.size() != 0) @(negedge clk_i);
    repeat (NOISE_LATENCY + 4) @(negedge clk_i);
  endtask

  function automatic logic signed [39:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return 40'({$urandom, $urandom});
      1: return 40'sh7F_FFFF_FFFF - $urandom_range(0, 3);
      2: return -40'sh80_0000_0000 + $urandom_range(0, 3);
      default: return 40'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
    endcase
  endfunction

  typedef struct {
    bit kd; logic [7:0] ix, vl; logic signed [39:0] xc, yc, zc;
    bit chk_lit; logic signed [15:0] lit;
  } stim_row_t;

  stim_row_t dir_rows [] = '{
    // integer lattice points give zero
    '{KIND_SAMPLE, 8'h00, 8'h00, 40'sd0, 40'sd0, 40'sd0, 1, 16'sd0},
    '{KIND_SAMPLE, 8'hFF, 8'hFF, 40'sh10000, 40'sh20000, 40'sh30000, 1, 16'sd0},
    '{KIND_SAMPLE, 8'h00, 8'h00, -40'sh80_0000_0000, 40'sh7F_FFFF_0000, 40'sd0, 1,
      16'sd0},
    '{KIND_SAMPLE, 8'h00, 8'h00, 40'sh7F_FFFF_FFFF, 40'sh7F_FFFF_FFFF,
      40'sh7F_FFFF_FFFF, 0, 0},
    '{KIND_SAMPLE, 8'h00, 8'h00, -40'sh80_0000_0000, -40'sh80_0000_0000, -40'sd1, 0, 0},
    '{KIND_SAMPLE, 8'h00, 8'h00, 40'sh8000, 40'sh8000, 40'sh8000, 0, 0},
    '{KIND_SAMPLE, 8'h00, 8'h00, 40'sh1_8001, -40'sh4000, 40'sh7FFF, 0, 0},
    '{KIND_SAMPLE, 8'h00, 8'h00, 40'shFF_FFFF, 40'sh00_0001, 40'shFF_0000, 0, 0}
  };

  initial begin
    logic [7:0] pv;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    offs = '{0, 0, 0};
    // load a full permutation
    for (int i = 0; i < 256; i++) begin
      pv = 8'(i * 167 + 13);
      send_beat(KIND_LOAD, 8'(i), pv, rnd_coord(), rnd_coord(), rnd_coord());
    end
    foreach (dir_rows[r])
      send_beat(dir_rows[r].kd, dir_rows[r].ix, dir_rows[r].vl, dir_rows[r].xc,
                dir_rows[r].yc, dir_rows[r].zc, dir_rows[r].chk_lit, dir_rows[r].lit);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      for (int a = 0; a < 3; a++)
        case (ph)
          0: apb_write(a, 32'h00FF_FFFF);
          1: apb_write(a, 32'h0);
          2: apb_write(a, 32'hFF00_0000 | $urandom);
          default: apb_write(a, $urandom);
        endcase
      stall_free = (ph == 1);
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(KIND_LOAD, 8'($urandom), 8'($urandom), rnd_coord(), rnd_coord(),
                    rnd_coord());
        else
          send_beat(KIND_SAMPLE, 8'($urandom), 8'($urandom), rnd_coord(), rnd_coord(),
                    rnd_coord());
        if (k == 60) begin
          in_valid_i <= 0;
          do @(negedge clk_i); while (noise_q.size() != 0);
        end
      end
      drain();
    end
    $display("covered %0d samples and %0d table loads over 5 offset settings",
             n_samples, n_loads);
    if (errors == 0) $display("[gradient_noise_3d_sampler_unit] OK");
    else $display("[gradient_noise_3d_sampler_unit] ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/gn3s_pkg.sv
src/gn3s_perm_ram.sv
src/gradient_noise_3d_sampler_unit.sv
src/gn3s_checker.sv
sim/tb_top.sv
